// File: hw/rtl/ptrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptrs_pkg;

	// Table size and result limits
	localparam int TASK_SLOTS_DEF = 16;
	localparam int MAX_RESULTS    = 16;
	localparam int SLOT_W         = 4;
	localparam int TIME_W         = 16;
	localparam int REQ_W          = 3;

	// Command queue depth, a power of two
	localparam int QDEPTH = 2;

	// Request codes on the input port
	localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SUSPEND = 3'd2;
	localparam logic [REQ_W-1:0] REQ_RESUME  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd4;

	// Decoded operation
	typedef enum logic [2:0] {
		OP_TICK,
		OP_CREATE,
		OP_SUSPEND,
		OP_RESUME,
		OP_DELETE,
		OP_NOP
	} op_t;

	// Input item
	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] first_delay;
	} in_t;

	// Result item
	typedef struct packed {
		logic              fired;
		logic [SLOT_W-1:0] fired_slot;
		logic              status;
		logic              last;
	} out_t;

	// Classified command between front and back
	typedef struct packed {
		op_t               op;
		logic              inrange;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] first_delay;
	} cmd_t;

	// One slot entry of the timing memory
	typedef struct packed {
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] count;
	} ent_t;

endpackage

`default_nettype wire

// File: hw/rtl/ptrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ptrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/ptrs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ptrs_front #(
	parameter int TASK_SLOTS = ptrs_pkg::TASK_SLOTS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire ptrs_pkg::in_t  req,
	output logic                busy,
	output logic                cmd_vld,
	output ptrs_pkg::cmd_t      cmd,
	input  wire logic           pop
);

	localparam int QDepth = ptrs_pkg::QDEPTH;
	localparam int PtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int CntW   = $clog2(QDepth + 1);
	localparam int CmpW   = 8;

	ptrs_pkg::cmd_t   q_mem_q [QDepth];
	ptrs_pkg::cmd_t   cls;
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             push;

	// Classify the request
	always_comb begin
		cls.slot        = req.slot;
		cls.period      = req.period;
		cls.first_delay = req.first_delay;
		cls.inrange     = CmpW'(req.slot) < CmpW'(TASK_SLOTS);
		case (req.req_type)
			ptrs_pkg::REQ_TICK:    cls.op = ptrs_pkg::OP_TICK;
			ptrs_pkg::REQ_CREATE:  cls.op = ptrs_pkg::OP_CREATE;
			ptrs_pkg::REQ_SUSPEND: cls.op = ptrs_pkg::OP_SUSPEND;
			ptrs_pkg::REQ_RESUME:  cls.op = ptrs_pkg::OP_RESUME;
			ptrs_pkg::REQ_DELETE:  cls.op = ptrs_pkg::OP_DELETE;
			default:               cls.op = ptrs_pkg::OP_NOP;
		endcase
	end

	assign busy    = (cnt_q == CntW'(QDepth));
	assign push    = start && !busy;
	assign cmd_vld = (cnt_q != '0);
	assign cmd     = q_mem_q[rd_ptr_q];

	// Hold classified commands until the back end takes them
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ptrs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ptrs_back #(
	parameter int TASK_SLOTS = ptrs_pkg::TASK_SLOTS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_vld,
	input  wire ptrs_pkg::cmd_t  cmd,
	output logic                 pop,
	output logic                 strobe,
	output ptrs_pkg::out_t       res
);

	localparam int IdxW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CntW  = $clog2(ptrs_pkg::MAX_RESULTS + 1);
	localparam int SlotW = ptrs_pkg::SLOT_W;
	localparam int TimeW = ptrs_pkg::TIME_W;
	localparam int EntW  = $bits(ptrs_pkg::ent_t);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(TASK_SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} st_t;

	st_t                  st_q;
	ptrs_pkg::op_t        op_q;
	logic [TASK_SLOTS-1:0] occ_q;
	logic [TASK_SLOTS-1:0] run_q;
	logic [IdxW-1:0]      idx_q;
	logic                 pend_q;
	logic [IdxW-1:0]      pend_slot_q;
	logic [CntW-1:0]      fire_cnt_q;
	logic                 strobe_q;
	ptrs_pkg::out_t       res_q;

	logic [IdxW-1:0]      sidx;
	logic                 create_ok;
	logic                 create_fail;
	ptrs_pkg::ent_t       cur;
	ptrs_pkg::ent_t       wdata;
	logic                 we;
	logic [IdxW-1:0]      waddr;
	logic [IdxW-1:0]      raddr;
	logic [EntW-1:0]      rdata;
	logic                 cur_run;
	logic                 cd_zero;
	logic                 fire;

	assign pop         = (st_q == ST_IDLE) && cmd_vld;
	assign sidx        = IdxW'(cmd.slot);
	assign create_ok   = cmd.inrange && !occ_q[sidx];
	assign create_fail = (cmd.op == ptrs_pkg::OP_CREATE) && !create_ok;
	assign cur         = ptrs_pkg::ent_t'(rdata);
	assign cur_run     = run_q[idx_q];
	assign cd_zero     = (cur.count == '0);
	assign fire        = (st_q == ST_WALK) && cur_run && cd_zero && occ_q[idx_q]
	                     && (fire_cnt_q < CntW'(ptrs_pkg::MAX_RESULTS));

	// Select the memory write: create fills an entry, the walk reloads or decrements
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = cur;
		raddr = (st_q == ST_WALK) ? idx_q + IdxW'(1) : '0;
		if (pop && (cmd.op == ptrs_pkg::OP_CREATE) && create_ok) begin
			we           = 1'b1;
			waddr        = sidx;
			wdata.period = cmd.period;
			wdata.count  = cmd.first_delay;
		end else if ((st_q == ST_WALK) && cur_run) begin
			we           = 1'b1;
			wdata.period = cur.period;
			wdata.count  = cd_zero ? cur.period - TimeW'(1) : cur.count - TimeW'(1);
		end
	end

	ptrs_ram #(
		.WIDTH (EntW),
		.DEPTH (TASK_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Result payload
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (pop) begin
					op_q           <= cmd.op;
					res_q.fired    <= 1'b0;
					res_q.fired_slot <= '0;
					res_q.status   <= create_fail;
					res_q.last     <= 1'b1;
				end
			end
			ST_WALK: begin
				// Release the held fire once a later one shows it was not the last
				if (fire) begin
					pend_slot_q      <= idx_q;
					res_q.fired      <= 1'b1;
					res_q.fired_slot <= SlotW'(pend_slot_q);
					res_q.status     <= 1'b0;
					res_q.last       <= 1'b0;
				end
			end
			ST_DONE: begin
				res_q.fired      <= pend_q;
				res_q.fired_slot <= pend_q ? SlotW'(pend_slot_q) : '0;
				res_q.status     <= 1'b0;
				res_q.last       <= 1'b1;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// Sequence the commands and the tick walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			occ_q      <= '0;
			run_q      <= '0;
			idx_q      <= '0;
			pend_q     <= 1'b0;
			fire_cnt_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					strobe_q <= pop && (cmd.op != ptrs_pkg::OP_TICK);
					if (pop) begin
						case (cmd.op)
							ptrs_pkg::OP_TICK: begin
								st_q       <= ST_WALK;
								idx_q      <= '0;
								pend_q     <= 1'b0;
								fire_cnt_q <= '0;
							end
							ptrs_pkg::OP_CREATE: begin
								if (create_ok) begin
									occ_q[sidx] <= 1'b1;
									run_q[sidx] <= 1'b1;
								end
							end
							ptrs_pkg::OP_SUSPEND: begin
								if (cmd.inrange) begin
									run_q[sidx] <= 1'b0;
								end
							end
							ptrs_pkg::OP_RESUME: begin
								if (cmd.inrange) begin
									run_q[sidx] <= 1'b1;
								end
							end
							ptrs_pkg::OP_DELETE: begin
								if (cmd.inrange) begin
									occ_q[sidx] <= 1'b0;
								end
							end
							default: begin
								st_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WALK: begin
					strobe_q <= fire && pend_q;
					if (fire) begin
						fire_cnt_q <= fire_cnt_q + CntW'(1);
						pend_q     <= 1'b1;
					end
					if (idx_q == LastIdx) begin
						st_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + IdxW'(1);
					end
				end
				ST_DONE: begin
					strobe_q <= 1'b1;
					pend_q   <= 1'b0;
					st_q     <= ST_IDLE;
				end
				default: begin
					strobe_q <= 1'b0;
					st_q     <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign res    = res_q;

`ifndef SYNTHESIS
	a_mid_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !res.last |-> (st_q == ST_WALK || st_q == ST_DONE))
		else $error("non-final result outside a tick walk");

	a_fire_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && res.fired |-> op_q == ptrs_pkg::OP_TICK)
		else $error("fired result from a non-tick command");

	a_status_create: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && res.status |-> !res.fired && op_q == ptrs_pkg::OP_CREATE)
		else $error("occupied status on a non-create result");

	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= CntW'(ptrs_pkg::MAX_RESULTS))
		else $error("fire count beyond result limit");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/periodic_task_release_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// A create, suspend, resume or delete waits in the command queue until the back end
// is idle, and its result is registered as it leaves the queue. A tick walks the slot
// table through one memory read port, one slot a cycle, releasing results as it goes.
// A 2-entry command queue takes requests while a tick walks; busy is high when it is full.
// Reset clears occupied and run flags and the queue; period and countdown memory is not
// cleared. Each result shows for one cycle under strobe; the receiver cannot stall.

module periodic_task_release_scheduler #(
	parameter int TASK_SLOTS = ptrs_pkg::TASK_SLOTS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire ptrs_pkg::in_t  req,
	output logic                busy,
	output logic                strobe,
	output ptrs_pkg::out_t      res
);

	logic           cmd_vld;
	ptrs_pkg::cmd_t cmd;
	logic           pop;

	// Classify and queue requests
	ptrs_front #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.cmd_vld (cmd_vld),
		.cmd     (cmd),
		.pop     (pop)
	);

	// Execute commands against the slot table
	ptrs_back #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_vld (cmd_vld),
		.cmd     (cmd),
		.pop     (pop),
		.strobe  (strobe),
		.res     (res)
	);

endmodule

`default_nettype wire

// File: tb/ptrs_release_checker.sv
`timescale 1ns / 1ps

module ptrs_release_checker #(
	parameter int TASK_SLOTS = ptrs_pkg::TASK_SLOTS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire ptrs_pkg::in_t  req,
	input  wire logic           busy,
	input  wire logic           strobe,
	input  wire ptrs_pkg::out_t res,
	output int                  errors,
	output int                  pending
);
	import ptrs_pkg::*;

	// Shadow of the slot table
	bit                occ_m [TASK_SLOTS];
	bit                run_m [TASK_SLOTS];
	logic [TIME_W-1:0] per_m [TASK_SLOTS];
	logic [TIME_W-1:0] cnt_m [TASK_SLOTS];

	// Releases and request outcomes still due from the block
	out_t release_q[$];
	int   err_cnt;

	assign errors = err_cnt;

	// Advance the shadow table by one request and queue what it releases
	task automatic predict_request(input in_t r);
		out_t o;
		int   n;
		bit   in_range;
		in_range = (int'(r.slot) < TASK_SLOTS);
		o = '0;
		if (r.req_type == REQ_TICK) begin
			n = 0;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				if (run_m[i]) begin
					if (cnt_m[i] == '0) begin
						if (occ_m[i] && n < MAX_RESULTS) begin
							o.fired = 1'b1;
							o.fired_slot = SLOT_W'(i);
							release_q.push_back(o);
							n++;
						end
						cnt_m[i] = per_m[i] - 16'd1;
					end else begin
						cnt_m[i] = cnt_m[i] - 16'd1;
					end
				end
			end
			if (n == 0) begin
				o = '0;
				o.last = 1'b1;
				release_q.push_back(o);
			end else begin
				o = release_q.pop_back();
				o.last = 1'b1;
				release_q.push_back(o);
			end
		end else begin
			if (r.req_type == REQ_CREATE) begin
				if (in_range && !occ_m[r.slot]) begin
					occ_m[r.slot] = 1'b1;
					run_m[r.slot] = 1'b1;
					per_m[r.slot] = r.period;
					cnt_m[r.slot] = r.first_delay;
				end else begin
					o.status = 1'b1;
				end
			end else if (in_range) begin
				case (r.req_type)
				REQ_SUSPEND: run_m[r.slot] = 1'b0;
				REQ_RESUME:  run_m[r.slot] = 1'b1;
				REQ_DELETE:  occ_m[r.slot] = 1'b0;
				default: ;
				endcase
			end
			o.last = 1'b1;
			release_q.push_back(o);
		end
	endtask

	// Compare one result field by field
	task automatic compare_result(input out_t got, input out_t want);
		if (got.fired !== want.fired) begin
			$error("fired: expected %0d, actual %0d", want.fired, got.fired);
			err_cnt++;
		end
		if (got.fired_slot !== want.fired_slot) begin
			$error("fired_slot: expected %0d, actual %0d", want.fired_slot, got.fired_slot);
			err_cnt++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, got.status);
			err_cnt++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, actual %0d", want.last, got.last);
			err_cnt++;
		end
	endtask

	// Match results first, then queue the request taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				occ_m[i] = 1'b0;
				run_m[i] = 1'b0;
				per_m[i] = '0;
				cnt_m[i] = '0;
			end
			release_q.delete();
			err_cnt = 0;
			pending <= 0;
		end else begin
			if (strobe) begin
				if (release_q.size() == 0) begin
					$error("result with nothing expected: fired %0d slot %0d status %0d last %0d",
						res.fired, res.fired_slot, res.status, res.last);
					err_cnt++;
				end else begin
					compare_result(res, release_q.pop_front());
				end
			end
			if (start && !busy)
				predict_request(req);
			pending <= release_q.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ptrs_pkg::*;

	localparam int SLOTS = TASK_SLOTS_DEF;

	logic clk;
	logic arst_n;
	logic start;
	in_t  req;
	logic busy;
	logic strobe;
	out_t res;
	int   errors;
	int   pending;

	// Occupancy as the stimulus sees it, and slots whose timing was ever written
	logic [SLOTS-1:0] taken;
	logic [SLOTS-1:0] written;
	bit               no_idle;

	periodic_task_release_scheduler #(
		.TASK_SLOTS(SLOTS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.strobe (strobe),
		.res    (res)
	);

	ptrs_release_checker #(
		.TASK_SLOTS(SLOTS)
	) i_release_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.strobe  (strobe),
		.res     (res),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic in_t make_req(input logic [REQ_W-1:0] kind, input int s,
			input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] dly);
		in_t r;
		r.req_type = kind;
		r.slot = SLOT_W'(s);
		r.period = per;
		r.first_delay = dly;
		return r;
	endfunction

	// Mostly short gaps, a few long, none inside a no-idle stretch
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (k < 50)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mix of well-formed task traffic with some noise; resume only written slots
	function automatic in_t random_req();
		in_t r;
		int  k;
		int  s;
		k = $urandom_range(0, 99);
		r.slot = SLOT_W'($urandom);
		r.period = ($urandom_range(0, 4) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(0, 6));
		r.first_delay = ($urandom_range(0, 4) == 0) ? TIME_W'($urandom) :
			TIME_W'($urandom_range(0, 5));
		if (k < 40) begin
			r.req_type = REQ_TICK;
		end else if (k < 65) begin
			r.req_type = REQ_CREATE;
		end else if (k < 75) begin
			r.req_type = REQ_SUSPEND;
		end else if (k < 85) begin
			if (written == '0) begin
				r.req_type = REQ_TICK;
			end else begin
				do s = $urandom_range(0, SLOTS - 1); while (!written[s]);
				r.req_type = REQ_RESUME;
				r.slot = SLOT_W'(s);
			end
		end else if (k < 95) begin
			r.req_type = REQ_DELETE;
		end else begin
			r.req_type = REQ_W'($urandom_range(int'(REQ_DELETE) + 1, (1 << REQ_W) - 1));
		end
		return r;
	endfunction

	// Hold the request until a transfer, then track occupancy
	task automatic send(input in_t item, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy);
		if (item.req_type == REQ_CREATE && !taken[item.slot]) begin
			taken[item.slot] = 1'b1;
			written[item.slot] = 1'b1;
		end else if (item.req_type == REQ_DELETE) begin
			taken[item.slot] = 1'b0;
		end
	endtask

	// Hold off the sender until every expected result has come
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		taken = '0;
		written = '0;
		no_idle = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: wraps, field extremes, occupied create, suspend/resume, delete
		send(make_req(REQ_CREATE, 0, 16'h0000, 16'h0000), 0);
		send(make_req(REQ_CREATE, 15, 16'hFFFF, 16'hFFFF), 0);
		send(make_req(REQ_CREATE, 0, 16'h0001, 16'h0001), 1);
		send(make_req(REQ_TICK, 0, 16'h0000, 16'h0000), 0);
		send(make_req(REQ_CREATE, 1, 16'h0001, 16'h0000), 0);
		send(make_req(REQ_CREATE, 2, 16'h0002, 16'h0001), 0);
		send(make_req(REQ_TICK, 15, 16'hFFFF, 16'hFFFF), 0);
		send(make_req(REQ_TICK, 0, 16'h0000, 16'h0000), 2);
		send(make_req(REQ_SUSPEND, 2, 16'h0000, 16'h0000), 0);
		send(make_req(REQ_TICK, 0, 16'h0000, 16'h0000), 0);
		send(make_req(REQ_CREATE, 2, 16'h0003, 16'h0003), 0);
		send(make_req(REQ_RESUME, 2, 16'h0000, 16'h0000), 0);
		send(make_req(REQ_DELETE, 1, 16'h0000, 16'h0000), 0);
		send(make_req(REQ_TICK, 0, 16'h0000, 16'h0000), 0);
		send(make_req(REQ_TICK, 0, 16'h0000, 16'h0000), 0);
		send(make_req(REQ_W'(int'(REQ_DELETE) + 1), 15, 16'hFFFF, 16'hFFFF), 0);
		send(make_req(REQ_W'(int'(REQ_DELETE) + 2), 5, 16'h5A5A, 16'hA5A5), 0);
		send(make_req(REQ_W'((1 << REQ_W) - 1), 10, 16'hA5A5, 16'h5A5A), 0);
		send(make_req(REQ_SUSPEND, 9, 16'h0000, 16'h0000), 0);
		send(make_req(REQ_DELETE, 15, 16'h0000, 16'h0000), 0);
		send(make_req(REQ_RESUME, 15, 16'h0000, 16'h0000), 0);
		send(make_req(REQ_CREATE, 8, 16'h5A5A, 16'hA5A5), 0);
		send(make_req(REQ_TICK, 0, 16'h0000, 16'h0000), 0);
		drain();

		// Random traffic with pauses for the block to run dry
		for (int n = 0; n < 400; n++) begin
			if (n % 50 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			if (n == 200) begin
				// Free, refill and run every slot so one tick releases the whole table
				drain();
				for (int s = 0; s < SLOTS; s++)
					send(make_req(REQ_DELETE, s, 16'h0000, 16'h0000), pick_gap());
				for (int s = 0; s < SLOTS; s++)
					send(make_req(REQ_CREATE, s, 16'h0001, 16'h0000), pick_gap());
				for (int s = 0; s < SLOTS; s++)
					send(make_req(REQ_RESUME, s, 16'h0000, 16'h0000), pick_gap());
				repeat (4) send(make_req(REQ_TICK, 0, 16'h0000, 16'h0000), pick_gap());
			end
			if (n % 90 == 89)
				drain();
			send(random_req(), pick_gap());
		end
		drain();
		repeat (2 * SLOTS + 8) @(posedge clk);

		if (errors == 0 && pending == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
